// File: rtl/udprc_pkg.sv
package udprc_pkg;

  // Protocol and length constants.
  localparam logic [15:0] UDP_PROTOCOL = 16'd17;
  localparam logic [15:0] HEADER_BYTES = 16'd8;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;

  // Position of each header field, counted in 16-bit words.
  localparam logic [14:0] WORD_SRC_PORT = 15'd0;
  localparam logic [14:0] WORD_DST_PORT = 15'd1;
  localparam logic [14:0] WORD_LENGTH   = 15'd2;
  localparam logic [14:0] WORD_CHECKSUM = 15'd3;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_BAD_LEN   = 2'd2,
    STATUS_BAD_CSUM  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } rx_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length_field;
    logic [15:0] payload_length;
    logic [15:0] header_checksum;
  } result_word_t;

  // Everything the final check needs, taken at the last byte of a datagram.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] payload_sum;
    logic [15:0] pad_word;
    logic [17:0] address_sum;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length;
    logic [15:0] checksum;
  } snap_t;

endpackage

// File: rtl/udp_receive_checker.sv
// UDP receive checker. Bytes of one UDP datagram (header first) arrive one per
// rx word, the final one flagged by last_byte; the addresses are sampled with
// the last byte. One byte is taken in every cycle while the input is not
// stalled, with no gaps between datagrams. Each last byte yields one result word,
// passed through the input, snapshot and result registers, carrying the status
// (ok, too short, bad length field or checksum error), the header ports, length
// and checksum, and the data length when ok. A zero checksum field skips the
// checksum test. Bytes beyond the 65535th are ignored and the datagram is
// treated as 65535 bytes long. The input stalls only when a last byte arrives
// while two earlier results are still waiting behind a stalled result port.
module udp_receive_checker import udprc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         rx_valid,
  output logic         rx_stall,
  input  rx_word_t     rx_word,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word
);

  // Pipeline registers.
  logic     hold_valid;
  rx_word_t hold_word;
  logic     snap_valid;
  snap_t    snap;

  // Per-datagram state.
  logic [15:0] byte_count;
  logic [15:0] running_sum;
  logic [7:0]  high_byte_hold;
  logic [15:0] cap_src_port;
  logic [15:0] cap_dst_port;
  logic [15:0] cap_length;
  logic [15:0] cap_checksum;

  logic [15:0] byte_count_next;
  logic [15:0] running_sum_next;
  logic [7:0]  high_byte_hold_next;
  logic [15:0] cap_src_port_next;
  logic [15:0] cap_dst_port_next;
  logic [15:0] cap_length_next;
  logic [15:0] cap_checksum_next;

  logic        result_free;
  logic        snap_free;
  logic        hold_process;
  logic        hold_free;
  logic        byte_taken;
  logic [15:0] pair_word;
  logic [16:0] pair_wide;
  logic [15:0] pair_sum;
  logic [17:0] address_sum;

  logic [18:0]  total_sum;
  logic [16:0]  fold_once;
  logic [15:0]  fold_sum;
  result_word_t result_next;

  // Flow control: a byte without the last flag never waits for the result side.
  assign result_free  = !result_valid || !result_stall;
  assign snap_free    = !snap_valid || result_free;
  assign hold_process = hold_valid && (!hold_word.last_byte || snap_free);
  assign hold_free    = !hold_valid || hold_process;
  assign rx_stall     = !hold_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_free) begin
      hold_valid <= rx_valid;
    end
    if (hold_free && rx_valid) begin
      hold_word <= rx_word;
    end
  end

  // Byte step: pair bytes into words, fold them into the sum, capture the header.
  always_comb begin
    byte_taken          = byte_count != COUNT_MAX;
    pair_word           = {high_byte_hold, hold_word.data_byte};
    pair_wide           = {1'b0, running_sum} + {1'b0, pair_word};
    pair_sum            = pair_wide[15:0] + {15'd0, pair_wide[16]};
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    high_byte_hold_next = high_byte_hold;
    cap_src_port_next   = cap_src_port;
    cap_dst_port_next   = cap_dst_port;
    cap_length_next     = cap_length;
    cap_checksum_next   = cap_checksum;
    if (byte_taken) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = hold_word.data_byte;
      end else begin
        running_sum_next = pair_sum;
        case (byte_count[15:1])
          WORD_SRC_PORT: cap_src_port_next = pair_word;
          WORD_DST_PORT: cap_dst_port_next = pair_word;
          WORD_LENGTH:   cap_length_next   = pair_word;
          WORD_CHECKSUM: cap_checksum_next = pair_word;
          default:       ;
        endcase
      end
      byte_count_next = byte_count + 16'd1;
    end
    address_sum = {2'b00, hold_word.source_address[31:16]}
                + {2'b00, hold_word.source_address[15:0]}
                + {2'b00, hold_word.dest_address[31:16]}
                + {2'b00, hold_word.dest_address[15:0]};
  end

  // State update; a processed last byte leaves the state clear for the next datagram.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_sum    <= '0;
      high_byte_hold <= '0;
      cap_src_port   <= '0;
      cap_dst_port   <= '0;
      cap_length     <= '0;
      cap_checksum   <= '0;
    end else if (hold_process) begin
      if (hold_word.last_byte) begin
        byte_count     <= '0;
        running_sum    <= '0;
        high_byte_hold <= '0;
        cap_src_port   <= '0;
        cap_dst_port   <= '0;
        cap_length     <= '0;
        cap_checksum   <= '0;
      end else begin
        byte_count     <= byte_count_next;
        running_sum    <= running_sum_next;
        high_byte_hold <= high_byte_hold_next;
        cap_src_port   <= cap_src_port_next;
        cap_dst_port   <= cap_dst_port_next;
        cap_length     <= cap_length_next;
        cap_checksum   <= cap_checksum_next;
      end
    end
  end

  // Snapshot register for the end-of-datagram check.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= hold_process && hold_word.last_byte;
    end
    if (hold_process && hold_word.last_byte) begin
      snap.byte_count  <= byte_count_next;
      snap.payload_sum <= running_sum_next;
      snap.pad_word    <= byte_count_next[0] ? {high_byte_hold_next, 8'h00} : 16'h0000;
      snap.address_sum <= address_sum;
      snap.source_port <= cap_src_port_next;
      snap.dest_port   <= cap_dst_port_next;
      snap.length      <= cap_length_next;
      snap.checksum    <= cap_checksum_next;
    end
  end

  // Final check: add the pseudo header and the pad, fold twice, then classify.
  always_comb begin
    total_sum = {1'b0, snap.address_sum} + {3'b000, snap.payload_sum}
              + {3'b000, snap.pad_word} + {3'b000, snap.byte_count}
              + {3'b000, UDP_PROTOCOL};
    fold_once = {1'b0, total_sum[15:0]} + {14'd0, total_sum[18:16]};
    fold_sum  = fold_once[15:0] + {15'd0, fold_once[16]};
    result_next.source_port     = snap.source_port;
    result_next.dest_port       = snap.dest_port;
    result_next.length_field    = snap.length;
    result_next.header_checksum = snap.checksum;
    result_next.payload_length  = 16'd0;
    if (snap.byte_count < HEADER_BYTES) begin
      result_next.status = STATUS_SHORT;
    end else if (snap.length < HEADER_BYTES || snap.length > snap.byte_count) begin
      result_next.status = STATUS_BAD_LEN;
    end else if (snap.checksum != 16'd0 && fold_sum != CSUM_GOOD) begin
      result_next.status = STATUS_BAD_CSUM;
    end else begin
      result_next.status         = STATUS_OK;
      result_next.payload_length = snap.length - HEADER_BYTES;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= snap_valid;
    end
    if (result_free && snap_valid) begin
      result_word <= result_next;
    end
  end

  // Only a last byte may be held back in the input register.
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold_process |-> hold_word.last_byte)
    else $error("non-final byte held in input register");

  // The state is clear after a datagram ends.
  assert property (@(posedge clk) disable iff (rst)
    hold_process && hold_word.last_byte |=> byte_count == 16'd0 && running_sum == 16'd0)
    else $error("state not cleared after last byte");

  // An ok datagram reports its length less the header.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status == STATUS_OK
      |-> result_word.payload_length == result_word.length_field - HEADER_BYTES)
    else $error("data length does not match length field");

  // Any status other than ok reports no data.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status != STATUS_OK |-> result_word.payload_length == 16'd0)
    else $error("data length reported for a failed datagram");

endmodule

// File: tb/tb_top.sv
module tb_top;
  import udprc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_BYTES = 570;
  localparam int RANDOM_DATAGRAMS = 12;

  // How the checksum field of a generated datagram is filled in.
  typedef enum {
    CSUM_FILL_GOOD,
    CSUM_FILL_ZERO,
    CSUM_FILL_BAD,
    CSUM_FILL_RAW
  } csum_fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  rx_word_t rx_word = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_word_t result_word;

  rx_word_t byte_queue[$];
  result_word_t predicted_results[$];
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int calm_from = 32'h7fffffff;
  int mismatches = 0;
  int cycles = 0;
  logic calm;

  // Predicted state of the checker.
  logic [15:0] rx_count;
  logic [15:0] rx_sum;
  logic [7:0]  rx_hold;
  logic [15:0] cap_src;
  logic [15:0] cap_dst;
  logic [15:0] cap_len;
  logic [15:0] cap_csum;

  udp_receive_checker dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_word(rx_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word(result_word)
  );

  always #5 clk = ~clk;

  // A stretch of the random part runs with neither side idling.
  assign calm = (bytes_accepted >= calm_from) && (bytes_accepted < calm_from + 250);

  // Ones' complement addition with the end-around carry.
  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic int field_mismatch(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Advance the predicted checker by one accepted word; a last byte yields a status.
  task automatic predict_byte(input rx_word_t w);
    logic [15:0] pair;
    logic [15:0] total;
    result_word_t r;
    if (rx_count != COUNT_MAX) begin
      if (!rx_count[0]) begin
        rx_hold = w.data_byte;
      end else begin
        pair = {rx_hold, w.data_byte};
        rx_sum = ones_add(rx_sum, pair);
        case (rx_count[15:1])
          WORD_SRC_PORT: cap_src = pair;
          WORD_DST_PORT: cap_dst = pair;
          WORD_LENGTH: cap_len = pair;
          WORD_CHECKSUM: cap_csum = pair;
          default: ;
        endcase
      end
      rx_count = rx_count + 16'd1;
    end
    if (w.last_byte) begin
      // Odd pad, pseudo header and received length complete the sum.
      total = rx_sum;
      if (rx_count[0]) total = ones_add(total, {rx_hold, 8'h00});
      total = ones_add(total, w.source_address[31:16]);
      total = ones_add(total, w.source_address[15:0]);
      total = ones_add(total, w.dest_address[31:16]);
      total = ones_add(total, w.dest_address[15:0]);
      total = ones_add(total, UDP_PROTOCOL);
      total = ones_add(total, rx_count);
      r = '0;
      r.source_port = cap_src;
      r.dest_port = cap_dst;
      r.length_field = cap_len;
      r.header_checksum = cap_csum;
      if (rx_count < HEADER_BYTES) begin
        r.status = STATUS_SHORT;
      end else if (cap_len < HEADER_BYTES || cap_len > rx_count) begin
        r.status = STATUS_BAD_LEN;
      end else if (cap_csum != 16'h0000 && total != CSUM_GOOD) begin
        r.status = STATUS_BAD_CSUM;
      end else begin
        r.status = STATUS_OK;
        r.payload_length = cap_len - HEADER_BYTES;
      end
      predicted_results.push_back(r);
      rx_count = '0;
      rx_sum = '0;
      rx_hold = '0;
      cap_src = '0;
      cap_dst = '0;
      cap_len = '0;
      cap_csum = '0;
    end
  endtask

  // Build one datagram of n bytes and queue its words; fill below zero means random bytes.
  task automatic queue_datagram(input int unsigned n, input logic [15:0] len_field,
                                input csum_fill_t mode, input logic [31:0] src,
                                input logic [31:0] dst, input int fill,
                                input bit addr_noise);
    logic [7:0] data[$];
    logic [15:0] acc;
    logic [15:0] csum;
    int unsigned used;
    rx_word_t w;
    for (int unsigned i = 0; i < n; i++) begin
      data.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    end
    if (n > 5) begin
      data[4] = len_field[15:8];
      data[5] = len_field[7:0];
    end
    // The checksum covers only the bytes the checker can count.
    if (n > 7 && mode != CSUM_FILL_RAW) begin
      data[6] = 8'h00;
      data[7] = 8'h00;
      used = (n > 65535) ? 65535 : n;
      acc = '0;
      for (int unsigned i = 0; i < used; i += 2) begin
        acc = ones_add(acc, {data[i], (i + 1 < used) ? data[i + 1] : 8'h00});
      end
      acc = ones_add(acc, src[31:16]);
      acc = ones_add(acc, src[15:0]);
      acc = ones_add(acc, dst[31:16]);
      acc = ones_add(acc, dst[15:0]);
      acc = ones_add(acc, UDP_PROTOCOL);
      acc = ones_add(acc, 16'(used));
      csum = ~acc;
      if (csum == 16'h0000) csum = 16'hFFFF;
      if (mode == CSUM_FILL_ZERO) csum = 16'h0000;
      else if (mode == CSUM_FILL_BAD) csum = csum ^ 16'($urandom_range(65535, 1));
      data[6] = csum[15:8];
      data[7] = csum[7:0];
    end
    for (int unsigned i = 0; i < n; i++) begin
      w.data_byte = data[i];
      w.last_byte = (i == n - 1);
      // Addresses only count at the last byte, so earlier ones may wander.
      w.source_address = (addr_noise && i != n - 1) ? $urandom : src;
      w.dest_address = (addr_noise && i != n - 1) ? $urandom : dst;
      byte_queue.push_back(w);
      bytes_queued++;
    end
  endtask

  // Driver: offers queued words, feeding the predictor at each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      rx_word <= '0;
      rx_count = '0;
      rx_sum = '0;
      rx_hold = '0;
      cap_src = '0;
      cap_dst = '0;
      cap_len = '0;
      cap_csum = '0;
    end else begin
      if (rx_valid && !rx_stall) begin
        predict_byte(rx_word);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!rx_valid || !rx_stall) begin
        if (byte_queue.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
          rx_valid <= 1'b1;
          rx_word <= byte_queue.pop_front();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result_word);
          mismatches++;
        end else begin
          result_word_t want;
          want = predicted_results.pop_front();
          mismatches += field_mismatch("status", 16'(want.status), 16'(result_word.status));
          mismatches += field_mismatch("source_port", want.source_port,
                                       result_word.source_port);
          mismatches += field_mismatch("dest_port", want.dest_port, result_word.dest_port);
          mismatches += field_mismatch("length_field", want.length_field,
                                       result_word.length_field);
          mismatches += field_mismatch("payload_length", want.payload_length,
                                       result_word.payload_length);
          mismatches += field_mismatch("header_checksum", want.header_checksum,
                                       result_word.header_checksum);
        end
      end
      result_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  // Watchdog against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    int random_start;
    int datagrams;
    logic [15:0] len_field;
    csum_fill_t mode;

    // Directed datagrams: short ones, field extremes, length and checksum cases.
    queue_datagram(1, 16'd0, CSUM_FILL_RAW, 32'h0, 32'h0, 8'hFF, 1'b0);
    queue_datagram(7, 16'd7, CSUM_FILL_RAW, 32'hFFFFFFFF, 32'h0, -1, 1'b0);
    queue_datagram(8, 16'd8, CSUM_FILL_GOOD, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b0);
    queue_datagram(8, 16'd8, CSUM_FILL_ZERO, 32'h0, 32'h0, 8'h00, 1'b0);
    queue_datagram(9, 16'd7, CSUM_FILL_GOOD, $urandom, $urandom, -1, 1'b0);
    queue_datagram(9, 16'd10, CSUM_FILL_GOOD, $urandom, $urandom, -1, 1'b0);
    queue_datagram(9, 16'd9, CSUM_FILL_BAD, $urandom, $urandom, -1, 1'b0);
    queue_datagram(10, 16'd9, CSUM_FILL_GOOD, $urandom, $urandom, -1, 1'b1);
    queue_datagram(11, 16'hFFFF, CSUM_FILL_GOOD, $urandom, $urandom, -1, 1'b0);

    // Random datagrams, a mix of well formed and broken ones.
    random_start = bytes_queued;
    calm_from = random_start + 100;
    datagrams = 0;
    while (bytes_queued - random_start < RANDOM_BYTES || datagrams < RANDOM_DATAGRAMS) begin
      pick = $urandom_range(99);
      if (pick < 10) n = $urandom_range(7, 1);
      else if (pick < 95) n = $urandom_range(48, 8);
      else n = $urandom_range(300, 49);
      pick = $urandom_range(99);
      if (pick < 60) len_field = 16'(n);
      else if (pick < 75) len_field = (n >= 8) ? 16'($urandom_range(n, 8)) : 16'(n);
      else if (pick < 85) len_field = 16'($urandom_range(7, 0));
      else if (pick < 92) len_field = 16'($urandom_range(65535, n + 1));
      else len_field = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) mode = CSUM_FILL_GOOD;
      else if (pick < 70) mode = CSUM_FILL_ZERO;
      else if (pick < 85) mode = CSUM_FILL_BAD;
      else mode = CSUM_FILL_RAW;
      queue_datagram(n, len_field, mode, $urandom, $urandom, -1,
                     $urandom_range(3) == 0);
      datagrams++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Drain: every word accepted and every prediction matched, then a short tail.
    while (bytes_accepted != bytes_queued || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/udprc_pkg.sv
rtl/udp_receive_checker.sv
tb/tb_top.sv
